// File: rtl/assert_macros.svh
// Assertion helpers used by the checker file hsv2rgb_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define HSV_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that is also checked across reset.
`define HSV_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

    localparam int FRAC_BITS = 16;
    localparam int HUE_W     = 16;
    localparam int IN_W      = 18;
    localparam int OUT_W     = 17;
    localparam int SEC_W     = 3;

    // clamped unit value 0..ONE
    localparam int S_W   = FRAC_BITS + 1;
    localparam int CL_W  = (IN_W - 1 > S_W) ? IN_W - 1 : S_W;
    localparam int EXT_W = (S_W > OUT_W) ? S_W : OUT_W;
    localparam int H6_W  = HUE_W + SEC_W;

    localparam logic [S_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam int GRAY_MIN_I = ((1 << FRAC_BITS) + 999) / 1000;
    localparam logic [S_W-1:0] GRAY_MIN = S_W'(GRAY_MIN_I);
    localparam logic [SEC_W-1:0] HUE_MUL = SEC_W'(6);

    typedef logic [S_W-1:0] t_unit;

    typedef enum logic [SEC_W-1:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } t_sector;

    typedef struct packed {
        t_sector sector;
        logic    gray;
    } t_ctl;

    // negative -> 0, above 1.0 -> ONE
    function automatic t_unit clamp_unit(logic signed [IN_W-1:0] x);
        logic [CL_W-1:0] mag;
        mag = CL_W'(x[IN_W-2:0]);
        if (x[IN_W-1]) begin
            return '0;
        end else if (mag > CL_W'(ONE)) begin
            return ONE;
        end else begin
            return S_W'(mag);
        end
    endfunction

    // channel onto the 17-bit output field, low bits kept
    function automatic logic [OUT_W-1:0] to_out(t_unit c);
        logic [EXT_W-1:0] e;
        e = EXT_W'(c);
        return e[OUT_W-1:0];
    endfunction

endpackage

// File: rtl/hsv2rgb_pix_if.sv
interface hsv2rgb_pix_if;
    import hsv2rgb_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [HUE_W-1:0]       hue;
    logic signed [IN_W-1:0] saturation;
    logic signed [IN_W-1:0] brightness;

    modport source (output valid, hue, saturation, brightness, input ready);
    modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

// File: rtl/hsv2rgb_rgb_if.sv
interface hsv2rgb_rgb_if;
    import hsv2rgb_pkg::*;

    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] red;
    logic [OUT_W-1:0] green;
    logic [OUT_W-1:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

// File: rtl/hsv2rgb_mux.sv
module hsv2rgb_mux (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  hsv2rgb_pkg::t_ctl              i_ctl,
    input  hsv2rgb_pkg::t_unit             i_v,
    input  hsv2rgb_pkg::t_unit             i_p,
    input  hsv2rgb_pkg::t_unit             i_q,
    input  hsv2rgb_pkg::t_unit             i_t,
    output logic [hsv2rgb_pkg::OUT_W-1:0]  o_red,
    output logic [hsv2rgb_pkg::OUT_W-1:0]  o_green,
    output logic [hsv2rgb_pkg::OUT_W-1:0]  o_blue
);
    import hsv2rgb_pkg::*;

    t_unit n_r, n_g, n_b;
    logic [OUT_W-1:0] r_red, r_green, r_blue;

    always_comb begin
        if (i_ctl.gray) begin
            n_r = i_v; n_g = i_v; n_b = i_v;
        end else begin
            case (i_ctl.sector)
                SEC_RED_YEL: begin n_r = i_v; n_g = i_t; n_b = i_p; end
                SEC_YEL_GRN: begin n_r = i_q; n_g = i_v; n_b = i_p; end
                SEC_GRN_CYN: begin n_r = i_p; n_g = i_v; n_b = i_t; end
                SEC_CYN_BLU: begin n_r = i_p; n_g = i_q; n_b = i_v; end
                SEC_BLU_MAG: begin n_r = i_t; n_g = i_p; n_b = i_v; end
                default:     begin n_r = i_v; n_g = i_p; n_b = i_q; end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_red   <= to_out(n_r);
            r_green <= to_out(n_g);
            r_blue  <= to_out(n_b);
        end
    end

    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

// File: rtl/hsv_to_rgb_convert_top.sv
// HSV to RGB pixel converter, four register stages.
// Throughput: one word per cycle when not stalled; each stage has its own valid
// bit and moves when the stage after it is empty or moving, so bubbles close up
// under back-pressure; stage 4 is the output register that drives o_rgb.
// Reset: i_rst_n synchronous, active low; clears the stage valid bits only.
module hsv_to_rgb_convert_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    hsv2rgb_pix_if.sink          i_pix,
    hsv2rgb_rgb_if.source        o_rgb
);
    import hsv2rgb_pkg::*;

    // Stage enables: a stage may load when it is empty or its word moves on.
    logic en1, en2, en3, en4;

    // ---------------- stage 1: clamp, hue * 6, gray test ----------------
    logic [H6_W-1:0]  h6;
    t_unit            n_s1_s, n_s1_v;
    t_ctl             n_s1_ctl;
    t_unit            r_s1_s, r_s1_v;
    logic [HUE_W-1:0] r_s1_f;
    t_ctl             r_s1_ctl;
    logic             r_s1_vld;

    // ---------------- stage 2: the (1 - s*x) factors ----------------
    logic [HUE_W:0]         fc;          // 1.0 - f in Q1.16, up to 65536
    logic [S_W+HUE_W-1:0]   prod_q;
    logic [S_W+HUE_W:0]     prod_t;
    t_unit                  n_s2_kp, n_s2_kq, n_s2_kt;
    t_unit                  r_s2_kp, r_s2_kq, r_s2_kt, r_s2_v;
    t_ctl                   r_s2_ctl;
    logic                   r_s2_vld;

    // ---------------- stage 3: v * factor ----------------
    logic [2*S_W-1:0] prod_p3, prod_q3, prod_t3;
    t_unit            r_s3_p, r_s3_q, r_s3_t, r_s3_v;
    t_ctl             r_s3_ctl;
    logic             r_s3_vld;

    // ---------------- stage 4: sector mux into output register ----------
    logic r_s4_vld;

    assign en4 = !r_s4_vld || o_rgb.ready;
    assign en3 = !r_s3_vld || en4;
    assign en2 = !r_s2_vld || en3;
    assign en1 = !r_s1_vld || en2;

    assign i_pix.ready = en1;

    // Stage 1. h6 = hue * 6: the top three bits are the sector (never above
    // five for a 16-bit hue), the low sixteen the position f inside it.
    always_comb begin
        h6               = H6_W'(i_pix.hue) * H6_W'(HUE_MUL);
        n_s1_s           = clamp_unit(i_pix.saturation);
        n_s1_v           = clamp_unit(i_pix.brightness);
        n_s1_ctl.sector  = t_sector'(h6[H6_W-1:HUE_W]);
        n_s1_ctl.gray    = (n_s1_s < GRAY_MIN);
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_s   <= n_s1_s;
            r_s1_v   <= n_s1_v;
            r_s1_f   <= h6[HUE_W-1:0];
            r_s1_ctl <= n_s1_ctl;
        end
    end

    // Stage 2. s*f and s*(1-f) are truncated to Q1.16 scale; both stay at or
    // below s, so the subtractions from ONE never go negative.
    always_comb begin
        fc      = {1'b1, {HUE_W{1'b0}}} - {1'b0, r_s1_f};
        prod_q  = (S_W+HUE_W)'(r_s1_s) * (S_W+HUE_W)'(r_s1_f);
        prod_t  = (S_W+HUE_W+1)'(r_s1_s) * (S_W+HUE_W+1)'(fc);
        n_s2_kp = ONE - r_s1_s;
        n_s2_kq = ONE - prod_q[S_W+HUE_W-1:HUE_W];
        n_s2_kt = ONE - prod_t[S_W+HUE_W-1:HUE_W];
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_kp  <= n_s2_kp;
            r_s2_kq  <= n_s2_kq;
            r_s2_kt  <= n_s2_kt;
            r_s2_v   <= r_s1_v;
            r_s2_ctl <= r_s1_ctl;
        end
    end

    // Stage 3. Three parallel v * k products, truncated by FRAC_BITS.
    always_comb begin
        prod_p3 = (2*S_W)'(r_s2_v) * (2*S_W)'(r_s2_kp);
        prod_q3 = (2*S_W)'(r_s2_v) * (2*S_W)'(r_s2_kq);
        prod_t3 = (2*S_W)'(r_s2_v) * (2*S_W)'(r_s2_kt);
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_p   <= prod_p3[FRAC_BITS+S_W-1:FRAC_BITS];
            r_s3_q   <= prod_q3[FRAC_BITS+S_W-1:FRAC_BITS];
            r_s3_t   <= prod_t3[FRAC_BITS+S_W-1:FRAC_BITS];
            r_s3_v   <= r_s2_v;
            r_s3_ctl <= r_s2_ctl;
        end
    end

    // Stage 4. Gray override and six-way channel order, registered.
    hsv2rgb_mux u_mux (
        .i_clk   (i_clk),
        .i_en    (en4),
        .i_ctl   (r_s3_ctl),
        .i_v     (r_s3_v),
        .i_p     (r_s3_p),
        .i_q     (r_s3_q),
        .i_t     (r_s3_t),
        .o_red   (o_rgb.red),
        .o_green (o_rgb.green),
        .o_blue  (o_rgb.blue)
    );

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else begin
            if (en1) r_s1_vld <= i_pix.valid;
            if (en2) r_s2_vld <= r_s1_vld;
            if (en3) r_s3_vld <= r_s2_vld;
            if (en4) r_s4_vld <= r_s3_vld;
        end
    end

    assign o_rgb.valid = r_s4_vld;

endmodule

// File: rtl/hsv2rgb_chk.sv
`include "assert_macros.svh"

module hsv2rgb_chk (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  logic signed [hsv2rgb_pkg::IN_W-1:0] i_in_sat,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic [hsv2rgb_pkg::OUT_W-1:0]      i_red,
    input  logic [hsv2rgb_pkg::OUT_W-1:0]      i_green,
    input  logic [hsv2rgb_pkg::OUT_W-1:0]      i_blue
);
    import hsv2rgb_pkg::*;

    // a waiting word is not withdrawn
    `HSV_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "output word dropped while stalled")

    // pipeline comes out of reset empty
    `HSV_ASSERT_NR(a_rst_empty, i_clk, !i_rst_n |=> !i_out_valid, "output valid straight after reset")

    // accepted word reaches the output while the receiver keeps ready high
    `HSV_ASSERT(a_latency, i_clk, i_rst_n, (i_in_valid && i_in_ready ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready) |=> i_out_valid, "word missing at output after four cycles")

    // negative saturation clamps to zero, so the pixel comes out gray
    `HSV_ASSERT(a_gray, i_clk, i_rst_n, (i_in_valid && i_in_ready && i_in_sat[IN_W-1] ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready) |=> (i_red == i_green && i_green == i_blue), "unsaturated pixel not gray")

endmodule

bind hsv_to_rgb_convert_top hsv2rgb_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_in_sat    (i_pix.saturation),
    .i_out_valid (o_rgb.valid),
    .i_out_ready (o_rgb.ready),
    .i_red       (o_rgb.red),
    .i_green     (o_rgb.green),
    .i_blue      (o_rgb.blue)
);

// File: sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hsv2rgb_pkg::*;

    // Clock and run limits
    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 9;
    localparam int IDLE_PERCENT   = 38;
    localparam int PIPE_LATENCY   = 4;    // register stages in the converter
    localparam int DRAIN_CYCLES   = 4 * PIPE_LATENCY;
    localparam int WATCHDOG_LIMIT = 2000; // cycles with no word moving on either side
    localparam int HOLD_CYCLES    = 250;  // long receiver hold-off
    localparam int HUE_SECTORS    = 6;

    // One RGB result word as the converter presents it
    typedef struct packed {
        logic [OUT_W-1:0] red;
        logic [OUT_W-1:0] green;
        logic [OUT_W-1:0] blue;
    } t_rgb_word;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    hsv2rgb_pix_if pix ();
    hsv2rgb_rgb_if rgb ();

    hsv_to_rgb_convert_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .o_rgb   (rgb)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    t_rgb_word rgb_expect_q[$];  // predicted colours, oldest first
    int        mismatches  = 0;
    int        rgb_words   = 0;  // result words seen so far
    int        quiet_count = 0;  // cycles since anything moved
    bit        idle_on     = 1'b1;
    int        hold_req    = 0;  // hold-off request from the test sequence
    int        hold_left   = 0;  // owned by the receiver process

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Signed fixed point onto 0..1.0: negatives give zero, overrange saturates.
    function automatic logic [63:0] unit_clamp(logic signed [IN_W-1:0] x);
        int xi;
        xi = x;
        if (xi < 0) begin
            return 64'd0;
        end else if (xi > int'(ONE)) begin
            return 64'(ONE);
        end
        return 64'(xi);
    endfunction

    function automatic t_rgb_word predict_rgb(logic [HUE_W-1:0] hue,
                                              logic signed [IN_W-1:0] sat,
                                              logic signed [IN_W-1:0] bri);
        logic [63:0] s, v, one_v, h6, f, p, q, t, r, g, b;
        t_sector     sec;
        t_rgb_word   w;
        one_v = 64'(ONE);
        s     = unit_clamp(sat);
        v     = unit_clamp(bri);
        if (s < 64'(GRAY_MIN)) begin
            // nearly unsaturated: plain grey at the brightness level
            r = v;
            g = v;
            b = v;
        end else begin
            h6  = 64'(hue) * HUE_SECTORS;
            sec = t_sector'(h6[HUE_W+SEC_W-1:HUE_W]);
            f   = h6 & ((64'd1 << HUE_W) - 1);
            p   = (v * (one_v - s)) >> FRAC_BITS;
            q   = (v * (one_v - ((s * f) >> HUE_W))) >> FRAC_BITS;
            t   = (v * (one_v - ((s * ((64'd1 << HUE_W) - f)) >> HUE_W))) >> FRAC_BITS;
            case (sec)
                SEC_RED_YEL: begin r = v; g = t; b = p; end
                SEC_YEL_GRN: begin r = q; g = v; b = p; end
                SEC_GRN_CYN: begin r = p; g = v; b = t; end
                SEC_CYN_BLU: begin r = p; g = q; b = v; end
                SEC_BLU_MAG: begin r = t; g = p; b = v; end
                default:     begin r = v; g = p; b = q; end
            endcase
        end
        w.red   = r[OUT_W-1:0];
        w.green = g[OUT_W-1:0];
        w.blue  = b[OUT_W-1:0];
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, longint got, longint want);
        mismatches++;
        $display("%0t: mismatch on %s (word %0d): got %0d, expected %0d",
                 $realtime, what, rgb_words, got, want);
    endtask

    // Both sides are sampled at the rising edge, before the converter's own
    // registers update. Output is checked before the input word of the same
    // edge is predicted; with four stages the two never meet anyway.
    always @(posedge i_clk) begin
        t_rgb_word want;
        if (i_rst_n) begin
            if (rgb.valid && rgb.ready) begin
                if (rgb_expect_q.size() == 0) begin
                    report_mismatch("unexpected word", rgb.red, -1);
                end else begin
                    want = rgb_expect_q.pop_front();
                    if (rgb.red !== want.red)
                        report_mismatch("red", rgb.red, want.red);
                    if (rgb.green !== want.green)
                        report_mismatch("green", rgb.green, want.green);
                    if (rgb.blue !== want.blue)
                        report_mismatch("blue", rgb.blue, want.blue);
                end
                rgb_words++;
            end
            if (pix.valid && pix.ready)
                rgb_expect_q.push_back(predict_rgb(pix.hue, pix.saturation, pix.brightness));

            if ((pix.valid && pix.ready) || (rgb.valid && rgb.ready))
                quiet_count = 0;
            else
                quiet_count++;
            // nothing has moved for far longer than any legal stall
            if (quiet_count >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired, %0d words outstanding",
                         $realtime, rgb_expect_q.size());
                $display("hsv_to_rgb_convert_top test failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random ready, plus long hold-offs on request
    // ------------------------------------------------------------------

    always @(negedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            rgb.ready <= 1'b0;
        end else begin
            rgb.ready <= !(idle_on && ($urandom_range(99) < IDLE_PERCENT));
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offers one pixel word at the falling edge and holds it until taken.
    // valid only drops when an idle cycle is drawn, so back-to-back words
    // keep it high without a glitch.
    task automatic send_pixel(logic [HUE_W-1:0] hue,
                              logic signed [IN_W-1:0] sat,
                              logic signed [IN_W-1:0] bri);
        @(negedge i_clk);
        while (idle_on && ($urandom_range(99) < IDLE_PERCENT)) begin
            pix.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix.valid      <= 1'b1;
        pix.hue        <= hue;
        pix.saturation <= sat;
        pix.brightness <= bri;
        do @(posedge i_clk); while (!pix.ready);
    endtask

    // Saturation/brightness mix: mostly in range, with grey-threshold,
    // overrange, negative and raw 18-bit values so every bit toggles.
    function automatic logic signed [IN_W-1:0] rand_level();
        case ($urandom_range(9))
            0:       return IN_W'($urandom);
            1:       return IN_W'($urandom_range(0, 2 * GRAY_MIN_I));
            2:       return IN_W'($urandom_range(int'(ONE), (1 << (IN_W - 1)) - 1));
            3:       return -IN_W'($urandom_range(1, 1 << (IN_W - 1)));
            default: return IN_W'($urandom_range(0, int'(ONE)));
        endcase
    endfunction

    task automatic send_random(int count);
        repeat (count)
            send_pixel(HUE_W'($urandom), rand_level(), rand_level());
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Corners: grey threshold, sector boundaries, clamping both ways
    task automatic test_directed();
        send_pixel(16'd0,     18'sd0,       18'sd65536);   // grey, full white
        send_pixel(16'd12345, 18'sd65,      18'sd40000);   // just under grey threshold
        send_pixel(16'd5000,  18'sd66,      18'sd65536);   // at threshold: coloured
        send_pixel(16'd0,     -18'sd1,      18'sd65536);   // negative sat -> grey
        send_pixel(16'd65535, -18'sd131072, 18'sd131071);  // most negative sat, max bri
        send_pixel(16'd0,     18'sd65536,   18'sd65536);   // sector boundaries follow
        send_pixel(16'd10922, 18'sd65536,   18'sd65536);
        send_pixel(16'd10923, 18'sd65536,   18'sd65536);
        send_pixel(16'd21845, 18'sd65536,   18'sd65536);
        send_pixel(16'd21846, 18'sd65536,   18'sd65536);
        send_pixel(16'd32768, 18'sd65536,   18'sd65536);
        send_pixel(16'd43690, 18'sd65536,   18'sd65536);
        send_pixel(16'd43691, 18'sd65536,   18'sd65536);
        send_pixel(16'd54613, 18'sd65536,   18'sd65536);
        send_pixel(16'd54614, 18'sd65536,   18'sd65536);
        send_pixel(16'd65535, 18'sd65536,   18'sd65536);
        send_pixel(16'd30000, 18'sd65536,   -18'sd5);      // negative bri -> black
        send_pixel(16'd30000, 18'sd65536,   18'sd100000);  // bri overrange
        send_pixel(16'd50000, 18'sd131071,  18'sd50000);   // sat overrange
        send_pixel(16'd50000, 18'sd65537,   18'sd50000);   // sat just past 1.0
        send_pixel(16'd20000, 18'sd40000,   18'sd0);       // zero brightness
        send_pixel(16'd20000, 18'sd40000,   18'sd65536);
        send_pixel(16'd1,     18'sd65536,   18'sd65536);
        send_pixel(16'd40000, -18'sd131072, -18'sd131072);
    endtask

    task automatic test_random_mix();
        idle_on = 1'b1;
        send_random(850);
    endtask

    // Receiver stops for a long stretch while the sender keeps offering,
    // so the stages fill and input ready must drop.
    task automatic test_back_pressure();
        idle_on  = 1'b0;
        hold_req = HOLD_CYCLES;
        send_random(75);
        idle_on  = 1'b1;
    endtask

    // No idling on either side: one word per clock end to end
    task automatic test_streaming();
        idle_on = 1'b0;
        send_random(300);
        idle_on = 1'b1;
    endtask

    initial begin
        pix.valid      = 1'b0;
        pix.hue        = '0;
        pix.saturation = '0;
        pix.brightness = '0;
        rgb.ready      = 1'b0;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_mix();
        test_back_pressure();
        test_streaming();

        @(negedge i_clk);
        pix.valid <= 1'b0;

        // drain; the watchdog guards against a hang here
        while (rgb_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (rgb_expect_q.size() != 0)
            report_mismatch("words left over", 0, rgb_expect_q.size());

        if (mismatches == 0) begin
            $display("hsv_to_rgb_convert_top test passed");
        end else begin
            $display("hsv_to_rgb_convert_top test failed");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/hsv2rgb_pkg.sv
rtl/hsv2rgb_pix_if.sv
rtl/hsv2rgb_rgb_if.sv
rtl/hsv2rgb_mux.sv
rtl/hsv_to_rgb_convert_top.sv
rtl/hsv2rgb_chk.sv
sim/testbench.sv
